// ===== hdl/hba_pkg.sv =====
// Shared constants for the best-fit heap allocator.
package hba_pkg;

    localparam int BYTES_W  = 22;
    localparam int UNIT_W   = 16;
    localparam int GROW_W   = 17;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // Word index of the growth register (paddr[2])
    localparam logic REG_GROW_MIN = 1'b0;

    localparam logic [GROW_W-1:0] GROW_MIN_RESET = 17'd4096;

endpackage

// ===== hdl/hba_header_ram.sv =====
// Single-port-write, single-port-read header memory with registered read data.
module hba_header_ram #(
    parameter int DEPTH = 65536,
    parameter int DW    = 17
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/best_fit_heap_allocator_unit.sv =====
// Top level of the best-fit heap allocator: chain walker, split/merge logic, register port.
// Operation: a request reads the headers on the chain, one header read per cycle, then
// updates headers as needed and issues the result. Throughput: one request at a time;
// the next request enters once the result is issued. Reset: asynchronous, active low; the
// heap becomes empty and grow_min_units returns to 4096. The header memory needs no
// clearing pass: only headers on the chain are ever read.
module best_fit_heap_allocator_unit #(
    parameter int HEAP_UNITS = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [hba_pkg::BYTES_W-1:0]    request_bytes,
    input  logic [hba_pkg::UNIT_W-1:0]     payload_unit,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hba_pkg::UNIT_W-1:0]     result_unit,
    output logic [hba_pkg::STATUS_W-1:0]   status,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hba_pkg::PADDR_W-1:0]    paddr,
    input  logic [hba_pkg::PDATA_W-1:0]    pwdata,
    output logic [hba_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    import hba_pkg::*;

    localparam int AW = $clog2(HEAP_UNITS);      // header address width
    localparam int TW = AW + 1;                  // heap top width (holds HEAP_UNITS)
    localparam int CW = (AW + 2 > 19) ? AW + 2 : 19; // arithmetic width
    localparam int DW = AW + 1;                  // header word: {used, size}

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_ALLOC_END,
        S_FREE_RIGHT,
        S_WRITE_A,
        S_WRITE_B,
        S_RESP
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         h_reg;
    logic [TW-1:0]         top_reg;
    logic [GROW_W-1:0]     grow_min_reg;
    logic                  cmd_reg;
    logic [CW-1:0]         need_reg;
    logic [CW-1:0]         target_reg;
    logic                  found_reg;
    logic [AW-1:0]         best_reg;
    logic [AW-1:0]         best_size_reg;
    logic                  has_left_reg;
    logic [AW-1:0]         left_reg;
    logic                  left_used_reg;
    logic [AW-1:0]         left_size_reg;
    logic [AW-1:0]         tsize_reg;
    logic                  right_ok_reg;
    logic [AW-1:0]         wa_a_reg;
    logic [DW-1:0]         wd_a_reg;
    logic                  b_en_reg;
    logic [AW-1:0]         wa_b_reg;
    logic [DW-1:0]         wd_b_reg;
    logic [CW-1:0]         res_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  out_valid_reg;
    logic [UNIT_W-1:0]     result_unit_reg;
    logic [STATUS_W-1:0]   status_out_reg;

    // memory interface
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DW-1:0]         rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DW-1:0]         wr_data;

    logic                  in_accept;
    logic                  cfg_write;
    logic                  rd_used;
    logic [AW-1:0]         rd_size;
    logic [CW-1:0]         h_ext;
    logic [CW-1:0]         nxt;
    logic                  nxt_in;
    logic [CW-1:0]         need_in;
    logic [CW-1:0]         grow;
    logic [CW-1:0]         top_ext;
    logic [CW-1:0]         left_merge;
    logic                  out_free;

    hba_header_ram #(
        .DEPTH (HEAP_UNITS),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_GROW_MIN);
    assign prdata    = (paddr[2] == REG_GROW_MIN) ? PDATA_W'(grow_min_reg) : '0;

    assign out_valid   = out_valid_reg;
    assign result_unit = result_unit_reg;
    assign status      = status_out_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // Decode the header read back for the current chain position
    assign rd_used = rd_data[AW];
    assign rd_size = rd_data[AW-1:0];
    assign h_ext   = CW'(h_reg);
    assign top_ext = CW'(top_reg);
    assign nxt     = h_ext + CW'(1) + CW'(rd_size);
    assign nxt_in  = (nxt < top_ext);

    // Round bytes up to 32-byte units
    assign need_in = CW'((({1'b0, request_bytes}) + (BYTES_W+1)'(31)) >> 5);

    // Growth amount: the larger of need + 1 and the configured minimum
    assign grow = ((need_reg + CW'(1)) < CW'(grow_min_reg)) ? CW'(grow_min_reg)
                                                           : (need_reg + CW'(1));

    assign left_merge = CW'(left_size_reg) + CW'(tsize_reg) + CW'(1);

    // Memory port control: reads follow the chain; writes come from the write-back states
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = wa_a_reg;
        wr_data = wd_a_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en   = in_accept;
                rd_addr = '0;
            end
            S_WALK:
            begin
                rd_en   = nxt_in;
                rd_addr = nxt[AW-1:0];
            end
            S_WRITE_A:
            begin
                wr_en = 1'b1;
            end
            S_WRITE_B:
            begin
                wr_en   = 1'b1;
                wr_addr = wa_b_reg;
                wr_data = wd_b_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            top_reg         <= '0;
            grow_min_reg    <= GROW_MIN_RESET;
            out_valid_reg   <= 1'b0;
            h_reg           <= '0;
            cmd_reg         <= CMD_ALLOC;
            need_reg        <= '0;
            target_reg      <= '0;
            found_reg       <= 1'b0;
            best_reg        <= '0;
            best_size_reg   <= '0;
            has_left_reg    <= 1'b0;
            left_reg        <= '0;
            left_used_reg   <= 1'b0;
            left_size_reg   <= '0;
            tsize_reg       <= '0;
            right_ok_reg    <= 1'b0;
            wa_a_reg        <= '0;
            wd_a_reg        <= '0;
            b_en_reg        <= 1'b0;
            wa_b_reg        <= '0;
            wd_b_reg        <= '0;
            res_reg         <= '0;
            status_reg      <= STATUS_OK;
            result_unit_reg <= '0;
            status_out_reg  <= STATUS_OK;
        end
        else
        begin
            if (cfg_write)
            begin
                grow_min_reg <= pwdata[GROW_W-1:0];
            end

            // Drop a result once it is taken; a new result loads it in S_RESP instead
            if (out_valid_reg && !out_stall && state_reg != S_RESP)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        cmd_reg      <= cmd;
                        need_reg     <= need_in;
                        target_reg   <= CW'(payload_unit) - CW'(1);
                        found_reg    <= 1'b0;
                        has_left_reg <= 1'b0;
                        h_reg        <= '0;
                        res_reg      <= '0;
                        if (cmd == CMD_ALLOC)
                        begin
                            state_reg <= (top_reg == '0) ? S_ALLOC_END : S_WALK;
                        end
                        else if (payload_unit == '0 || top_reg == '0)
                        begin
                            status_reg <= STATUS_NOT_FOUND;
                            state_reg  <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_WALK;
                        end
                    end
                end

                S_WALK:
                begin
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        // Keep the smallest fitting free block, lowest address on ties
                        if (!rd_used && CW'(rd_size) >= need_reg &&
                            (!found_reg || rd_size < best_size_reg))
                        begin
                            found_reg     <= 1'b1;
                            best_reg      <= h_reg;
                            best_size_reg <= rd_size;
                        end
                        h_reg <= nxt[AW-1:0];
                        if (!nxt_in)
                        begin
                            state_reg <= S_ALLOC_END;
                        end
                    end
                    else if (h_ext == target_reg)
                    begin
                        tsize_reg    <= rd_size;
                        right_ok_reg <= nxt_in;
                        state_reg    <= S_FREE_RIGHT;
                    end
                    else
                    begin
                        has_left_reg  <= 1'b1;
                        left_reg      <= h_reg;
                        left_used_reg <= rd_used;
                        left_size_reg <= rd_size;
                        h_reg         <= nxt[AW-1:0];
                        if (!nxt_in)
                        begin
                            status_reg <= STATUS_NOT_FOUND;
                            state_reg  <= S_RESP;
                        end
                    end
                end

                S_ALLOC_END:
                begin
                    status_reg <= STATUS_OK;
                    if (found_reg)
                    begin
                        res_reg  <= CW'(best_reg) + CW'(1);
                        wa_a_reg <= best_reg;
                        if (CW'(best_size_reg) - need_reg < CW'(2))
                        begin
                            wd_a_reg <= {1'b1, best_size_reg};
                            b_en_reg <= 1'b0;
                        end
                        else
                        begin
                            // Split: used part of the need, free remainder behind it
                            wd_a_reg <= {1'b1, need_reg[AW-1:0]};
                            b_en_reg <= 1'b1;
                            wa_b_reg <= AW'(CW'(best_reg) + CW'(1) + need_reg);
                            wd_b_reg <= {1'b0,
                                         AW'(CW'(best_size_reg) - need_reg - CW'(1))};
                        end
                        state_reg <= S_WRITE_A;
                    end
                    else if (top_ext + grow > CW'(HEAP_UNITS))
                    begin
                        status_reg <= STATUS_FULL;
                        state_reg  <= S_RESP;
                    end
                    else
                    begin
                        // Grow the heap top and carve the new region
                        top_reg  <= TW'(top_ext + grow);
                        res_reg  <= top_ext + CW'(1);
                        wa_a_reg <= top_reg[AW-1:0];
                        if (grow - CW'(1) - need_reg < CW'(2))
                        begin
                            wd_a_reg <= {1'b1, AW'(grow - CW'(1))};
                            b_en_reg <= 1'b0;
                        end
                        else
                        begin
                            wd_a_reg <= {1'b1, need_reg[AW-1:0]};
                            b_en_reg <= 1'b1;
                            wa_b_reg <= AW'(top_ext + CW'(1) + need_reg);
                            wd_b_reg <= {1'b0, AW'(grow - CW'(2) - need_reg)};
                        end
                        state_reg <= S_WRITE_A;
                    end
                end

                S_FREE_RIGHT:
                begin
                    // rd_data holds the right neighbor when right_ok_reg is set
                    status_reg <= STATUS_OK;
                    b_en_reg   <= 1'b0;
                    if (has_left_reg && !left_used_reg)
                    begin
                        wa_a_reg <= left_reg;
                        if (right_ok_reg && !rd_used)
                        begin
                            wd_a_reg <= {1'b0, AW'(left_merge + CW'(rd_size) + CW'(1))};
                        end
                        else
                        begin
                            wd_a_reg <= {1'b0, AW'(left_merge)};
                        end
                    end
                    else
                    begin
                        wa_a_reg <= target_reg[AW-1:0];
                        if (right_ok_reg && !rd_used)
                        begin
                            wd_a_reg <= {1'b0,
                                         AW'(CW'(tsize_reg) + CW'(rd_size) + CW'(1))};
                        end
                        else
                        begin
                            wd_a_reg <= {1'b0, tsize_reg};
                        end
                    end
                    state_reg <= S_WRITE_A;
                end

                S_WRITE_A:
                begin
                    state_reg <= b_en_reg ? S_WRITE_B : S_RESP;
                end

                S_WRITE_B:
                begin
                    state_reg <= S_RESP;
                end

                S_RESP:
                begin
                    // Hold until the result register is free
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        result_unit_reg <= res_reg[UNIT_W-1:0];
                        status_out_reg  <= status_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
